// ===== src/gaps_pkg.sv =====
// Package for the grid path search: sizes, cell states, result codes, sequencer states.
// No dependencies; used by every module under src.
`default_nettype none
package gaps_pkg;
    localparam int GRID_SIDE_DEF = 8;
    // cell index is {row, column}, three bits each
    localparam int CELL_BITS     = 6;
    localparam int CELLS         = 1 << CELL_BITS;
    localparam int COUNT_BITS    = CELL_BITS + 1;
    localparam logic [3:0] NBR_DONE = 4'd8;
    localparam logic [1:0] ST_NONE   = 2'd0;
    localparam logic [1:0] ST_OPEN   = 2'd1;
    localparam logic [1:0] ST_CLOSED = 2'd2;
    localparam logic [1:0] RS_ROUTE  = 2'd0;
    localparam logic [1:0] RS_NOPATH = 2'd1;
    localparam logic [1:0] RS_SAME   = 2'd2;
    localparam logic [2:0] CFG_W  = 3'd0;
    localparam logic [2:0] CFG_H  = 3'd1;
    localparam logic [2:0] CFG_SX = 3'd2;
    localparam logic [2:0] CFG_SY = 3'd3;
    localparam logic [2:0] CFG_GX = 3'd4;
    localparam logic [2:0] CFG_GY = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_NBR, S_NBR_CHK, S_SEL_LIST, S_SEL_CELL, S_SEL_CMP,
        S_LOAD_CUR, S_TRACE_RD, S_TRACE_OUT, S_FAIL, S_SAME
    } state_t;
endpackage
`default_nettype wire

// ===== src/gaps_open_list.sv =====
// Open list kept in insertion order: append-only, one registered read port.
// Depends on gaps_pkg.
`default_nettype none
module gaps_open_list #(
    parameter int CELLS = gaps_pkg::CELLS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           clr,
    input  wire logic                           push,
    input  wire logic [gaps_pkg::CELL_BITS-1:0] push_cell,
    input  wire logic [$clog2(CELLS)-1:0]       rd_pos,
    output logic      [gaps_pkg::CELL_BITS-1:0] rd_cell,
    output logic      [$clog2(CELLS+1)-1:0]     count
);
    localparam int IW = $clog2(CELLS);
    logic [gaps_pkg::CELL_BITS-1:0] mem [CELLS];
    logic [gaps_pkg::CELL_BITS-1:0] rd_cell_reg;
    logic [$clog2(CELLS+1)-1:0]     count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[count_reg[IW-1:0]] <= push_cell;
        end
        rd_cell_reg <= mem[rd_pos];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (clr)
        begin
            count_reg <= '0;
        end
        else if (push)
        begin
            count_reg <= count_reg + 1'b1;
        end
    end

    assign rd_cell = rd_cell_reg;
    assign count = count_reg;
endmodule
`default_nettype wire

// ===== src/grid_astar_path_search.sv =====
// A* route search on an 8-connected grid of up to 8x8 cells. A load word (op 0)
// is taken and busy stays low. A search word (op 1) raises busy and, unless start
// equals goal, first clears the cell state store. Each expansion then checks every
// neighbor slot, reads the store for a neighbor inside the grid, closes the cell,
// and picks the next cell by rescanning every cell ever put on the open list.
// Route words come goal first with start excluded; a no-path or start-equals-goal
// result is a single word.
// Each word is valid for one cycle on out_valid, the receiver cannot stall, and
// the final word carries last. Write configuration only while busy is low.
`default_nettype none
module grid_astar_path_search #(
    parameter int GRID_SIDE = gaps_pkg::GRID_SIDE_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic       op,
    input  wire logic [2:0] cell_x,
    input  wire logic [2:0] cell_y,
    input  wire logic       walkable,
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [3:0] cfg_data,
    output logic            out_valid,
    output logic [2:0]      route_x,
    output logic [2:0]      route_y,
    output logic [1:0]      status,
    output logic            last
);
    localparam int CB = gaps_pkg::CELL_BITS;
    localparam int CELLS = gaps_pkg::CELLS;
    localparam int PW = gaps_pkg::COUNT_BITS;
    localparam logic [3:0] SIDE4 = 4'(GRID_SIDE);

    gaps_pkg::state_t state_reg, state_next;

    logic [3:0] gw_reg, gh_reg;
    logic [2:0] sx_reg, sy_reg, gx_reg, gy_reg;

    // per-cell store
    logic          walk_mem [CELLS];
    logic [1:0]    st_mem [CELLS];
    logic [CB-1:0] par_mem [CELLS];
    logic [6:0]    cost_mem [CELLS];
    logic [7:0]    score_mem [CELLS];

    logic          walk_rd_reg;
    logic [1:0]    st_rd_reg;
    logic [CB-1:0] par_rd_reg;
    logic [6:0]    cost_rd_reg;
    logic [7:0]    score_rd_reg;

    logic [2:0]    cx_reg, cx_next, cy_reg, cy_next;
    logic [6:0]    ccost_reg, ccost_next;
    logic [3:0]    nb_reg, nb_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [CB-1:0] best_reg, best_next;
    logic [7:0]    bscore_reg, bscore_next;
    logic          bvalid_reg, bvalid_next;
    logic [CB-1:0] clr_reg, clr_next;
    logic [CB-1:0] trace_reg, trace_next;

    logic [3:0] wdim, hdim, wm1, hm1;
    logic [2:0] w1, h1, sxc, syc, gxc, gyc;

    always_comb
    begin
        wdim = (gw_reg == 4'd0) ? 4'd1 : ((gw_reg > SIDE4) ? SIDE4 : gw_reg);
        hdim = (gh_reg == 4'd0) ? 4'd1 : ((gh_reg > SIDE4) ? SIDE4 : gh_reg);
        wm1 = wdim - 4'd1;
        hm1 = hdim - 4'd1;
        w1 = wm1[2:0];
        h1 = hm1[2:0];
        sxc = (sx_reg > w1) ? w1 : sx_reg;
        syc = (sy_reg > h1) ? h1 : sy_reg;
        gxc = (gx_reg > w1) ? w1 : gx_reg;
        gyc = (gy_reg > h1) ? h1 : gy_reg;
    end

    logic [CB-1:0] s_idx, g_idx, cur_idx;
    assign s_idx = {syc, sxc};
    assign g_idx = {gyc, gxc};
    assign cur_idx = {cy_reg, cx_reg};

    // neighbor offsets plus one: column outer, row inner, center skipped
    function automatic logic [3:0] nbr_offset(input logic [3:0] k);
        logic [3:0] r;
        case (k)
            4'd0:    r = {2'd0, 2'd0};
            4'd1:    r = {2'd0, 2'd1};
            4'd2:    r = {2'd0, 2'd2};
            4'd3:    r = {2'd1, 2'd0};
            4'd4:    r = {2'd1, 2'd2};
            4'd5:    r = {2'd2, 2'd0};
            4'd6:    r = {2'd2, 2'd1};
            4'd7:    r = {2'd2, 2'd2};
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    logic [3:0]    noff;
    logic [3:0]    nx4, ny4;
    logic          nb_in;
    logic [CB-1:0] n_idx;
    logic [2:0]    hdx, hdy, heur;
    logic [6:0]    ncost;
    logic [7:0]    nscore;

    assign noff = nbr_offset(nb_reg);
    // a step left of column zero wraps to 15 and fails the range check
    assign nx4 = {1'b0, cx_reg} + {2'b0, noff[3:2]} - 4'd1;
    assign ny4 = {1'b0, cy_reg} + {2'b0, noff[1:0]} - 4'd1;
    assign nb_in = (nx4 <= {1'b0, w1}) && (ny4 <= {1'b0, h1});
    assign n_idx = {ny4[2:0], nx4[2:0]};
    assign hdx = (nx4[2:0] > gxc) ? nx4[2:0] - gxc : gxc - nx4[2:0];
    assign hdy = (ny4[2:0] > gyc) ? ny4[2:0] - gyc : gyc - ny4[2:0];
    assign heur = (hdx > hdy) ? hdx : hdy;
    assign ncost = ccost_reg + 7'd1;
    assign nscore = {1'b0, ncost} + {5'd0, heur};

    // open list
    logic          ol_clr, ol_push;
    logic [CB-1:0] ol_rd_cell;
    logic [PW-1:0] ol_count;

    gaps_open_list #(.CELLS(CELLS)) u_open (
        .clk(clk), .rst_n(rst_n), .clr(ol_clr), .push(ol_push), .push_cell(n_idx),
        .rd_pos(pos_reg[CB-1:0]), .rd_cell(ol_rd_cell), .count(ol_count)
    );

    // cell store controls
    logic          load_we;
    logic          wr_clear, wr_open, wr_close;
    logic [CB-1:0] mem_raddr;

    assign load_we = (state_reg == gaps_pkg::S_IDLE) && start && !op
                     && ({1'b0, cell_x} < SIDE4) && ({1'b0, cell_y} < SIDE4);

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            walk_mem[{cell_y, cell_x}] <= walkable;
        end
        if (wr_clear)
        begin
            st_mem[clr_reg] <= gaps_pkg::ST_NONE;
        end
        else if (wr_open)
        begin
            st_mem[n_idx] <= gaps_pkg::ST_OPEN;
        end
        else if (wr_close)
        begin
            st_mem[cur_idx] <= gaps_pkg::ST_CLOSED;
        end
        if (wr_open)
        begin
            par_mem[n_idx]   <= cur_idx;
            cost_mem[n_idx]  <= ncost;
            score_mem[n_idx] <= nscore;
        end
        walk_rd_reg  <= walk_mem[mem_raddr];
        st_rd_reg    <= st_mem[mem_raddr];
        par_rd_reg   <= par_mem[mem_raddr];
        cost_rd_reg  <= cost_mem[mem_raddr];
        score_rd_reg <= score_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg <= 4'd8; gh_reg <= 4'd8;
            sx_reg <= 3'd0; sy_reg <= 3'd0; gx_reg <= 3'd7; gy_reg <= 3'd7;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gaps_pkg::CFG_W:  gw_reg <= cfg_data;
                gaps_pkg::CFG_H:  gh_reg <= cfg_data;
                gaps_pkg::CFG_SX: sx_reg <= cfg_data[2:0];
                gaps_pkg::CFG_SY: sy_reg <= cfg_data[2:0];
                gaps_pkg::CFG_GX: gx_reg <= cfg_data[2:0];
                gaps_pkg::CFG_GY: gy_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gaps_pkg::S_IDLE;
            cx_reg <= '0; cy_reg <= '0; ccost_reg <= '0;
            nb_reg <= '0; pos_reg <= '0; best_reg <= '0; bscore_reg <= '0;
            bvalid_reg <= 1'b0; clr_reg <= '0; trace_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cx_reg <= cx_next; cy_reg <= cy_next; ccost_reg <= ccost_next;
            nb_reg <= nb_next; pos_reg <= pos_next; best_reg <= best_next;
            bscore_reg <= bscore_next; bvalid_reg <= bvalid_next;
            clr_reg <= clr_next; trace_reg <= trace_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cx_next = cx_reg; cy_next = cy_reg; ccost_next = ccost_reg;
        nb_next = nb_reg; pos_next = pos_reg; best_next = best_reg;
        bscore_next = bscore_reg; bvalid_next = bvalid_reg;
        clr_next = clr_reg; trace_next = trace_reg;
        case (state_reg)
            gaps_pkg::S_IDLE:
            begin
                if (start && op)
                begin
                    cx_next = sxc; cy_next = syc; ccost_next = '0;
                    nb_next = '0; clr_next = '0;
                    state_next = (s_idx == g_idx) ? gaps_pkg::S_SAME : gaps_pkg::S_CLEAR;
                end
            end
            gaps_pkg::S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CB'(CELLS - 1))
                begin
                    state_next = gaps_pkg::S_NBR;
                end
            end
            gaps_pkg::S_NBR:
            begin
                if (nb_reg == gaps_pkg::NBR_DONE)
                begin
                    pos_next = '0;
                    bvalid_next = 1'b0;
                    state_next = gaps_pkg::S_SEL_LIST;
                end
                else if (nb_in)
                begin
                    state_next = gaps_pkg::S_NBR_CHK;
                end
                else
                begin
                    nb_next = nb_reg + 4'd1;
                end
            end
            gaps_pkg::S_NBR_CHK:
            begin
                nb_next = nb_reg + 4'd1;
                state_next = gaps_pkg::S_NBR;
            end
            gaps_pkg::S_SEL_LIST:
            begin
                if (pos_reg >= ol_count)
                begin
                    state_next = bvalid_reg ? gaps_pkg::S_LOAD_CUR : gaps_pkg::S_FAIL;
                end
                else
                begin
                    state_next = gaps_pkg::S_SEL_CELL;
                end
            end
            gaps_pkg::S_SEL_CELL:
            begin
                state_next = gaps_pkg::S_SEL_CMP;
            end
            gaps_pkg::S_SEL_CMP:
            begin
                // skip closed entries; strict less-than keeps the earliest on a tie
                if (st_rd_reg == gaps_pkg::ST_OPEN && (!bvalid_reg || score_rd_reg < bscore_reg))
                begin
                    best_next = ol_rd_cell;
                    bscore_next = score_rd_reg;
                    bvalid_next = 1'b1;
                end
                pos_next = pos_reg + 1'b1;
                state_next = gaps_pkg::S_SEL_LIST;
            end
            gaps_pkg::S_LOAD_CUR:
            begin
                cx_next = best_reg[2:0];
                cy_next = best_reg[5:3];
                ccost_next = cost_rd_reg;
                nb_next = '0;
                trace_next = best_reg;
                state_next = (best_reg == g_idx) ? gaps_pkg::S_TRACE_RD : gaps_pkg::S_NBR;
            end
            gaps_pkg::S_TRACE_RD:
            begin
                state_next = gaps_pkg::S_TRACE_OUT;
            end
            gaps_pkg::S_TRACE_OUT:
            begin
                trace_next = par_rd_reg;
                state_next = (par_rd_reg == s_idx) ? gaps_pkg::S_IDLE : gaps_pkg::S_TRACE_RD;
            end
            gaps_pkg::S_FAIL, gaps_pkg::S_SAME:
            begin
                state_next = gaps_pkg::S_IDLE;
            end
            default:
            begin
                state_next = gaps_pkg::S_IDLE;
            end
        endcase
    end

    // outputs and store controls
    always_comb
    begin
        busy = (state_reg != gaps_pkg::S_IDLE);
        out_valid = 1'b0;
        route_x = '0; route_y = '0; status = gaps_pkg::RS_ROUTE; last = 1'b0;
        mem_raddr = trace_reg;
        wr_clear = 1'b0; wr_open = 1'b0; wr_close = 1'b0;
        ol_clr = 1'b0; ol_push = 1'b0;
        case (state_reg)
            gaps_pkg::S_IDLE:
            begin
                ol_clr = start && op;
            end
            gaps_pkg::S_CLEAR:
            begin
                wr_clear = 1'b1;
            end
            gaps_pkg::S_NBR:
            begin
                mem_raddr = n_idx;
                wr_close = (nb_reg == gaps_pkg::NBR_DONE);
            end
            gaps_pkg::S_NBR_CHK:
            begin
                // admit a fresh neighbor that is walkable or is the goal
                if (st_rd_reg == gaps_pkg::ST_NONE && (walk_rd_reg || n_idx == g_idx))
                begin
                    wr_open = 1'b1;
                    ol_push = 1'b1;
                end
            end
            gaps_pkg::S_SEL_LIST:
            begin
                mem_raddr = best_reg;
            end
            gaps_pkg::S_SEL_CELL:
            begin
                mem_raddr = ol_rd_cell;
            end
            gaps_pkg::S_TRACE_OUT:
            begin
                out_valid = 1'b1;
                route_x = trace_reg[2:0];
                route_y = trace_reg[5:3];
                last = (par_rd_reg == s_idx);
            end
            gaps_pkg::S_FAIL:
            begin
                out_valid = 1'b1; status = gaps_pkg::RS_NOPATH; last = 1'b1;
            end
            gaps_pkg::S_SAME:
            begin
                out_valid = 1'b1; status = gaps_pkg::RS_SAME; last = 1'b1;
            end
            default: ;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> busy)
        else $error("result outside a search");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != gaps_pkg::RS_ROUTE) |-> last)
        else $error("status word without last");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |=> !busy)
        else $error("search kept running after last word");
endmodule
`default_nettype wire
